@@ hdl/pls_pkg.sv @@
package pls_pkg;

	localparam int OP_W = 4;
	localparam int VAL_W = 32;
	localparam int POS_W = 5;
	localparam int ST_W = 2;
	localparam int CNT_W = 5;
	localparam int CAPACITY_DEF = 16;

	localparam logic signed [VAL_W-1:0] ERR_VALUE = {VAL_W{1'b1}};

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 4'd0,
		OP_PUSH_BACK  = 4'd1,
		OP_INSERT_AT  = 4'd2,
		OP_POP_FRONT  = 4'd3,
		OP_POP_BACK   = 4'd4,
		OP_REMOVE_AT  = 4'd5,
		OP_READ_FRONT = 4'd6,
		OP_READ_BACK  = 4'd7,
		OP_READ_AT    = 4'd8,
		OP_CLEAR      = 4'd9
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_BADPOS = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_REMOVE
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t               kind;
		logic signed [VAL_W-1:0] value;
	} cell_ctl_t;

endpackage

@@ hdl/pls_cell.sv @@
module pls_cell #(
	parameter int CountWidth = 5,
	parameter int Index = 0
) (
	input  logic                              clk,
	input  pls_pkg::cell_ctl_t                ctl,
	input  logic [CountWidth-1:0]             at,
	input  logic signed [pls_pkg::VAL_W-1:0]  left_data,
	input  logic signed [pls_pkg::VAL_W-1:0]  right_data,
	output logic signed [pls_pkg::VAL_W-1:0]  data,
	output logic signed [pls_pkg::VAL_W-1:0]  rd_term
);

	localparam logic [CountWidth-1:0] IDX = CountWidth'(Index);

	logic signed [pls_pkg::VAL_W-1:0] data_q;
	logic signed [pls_pkg::VAL_W-1:0] data_d;
	logic                             hit;
	logic                             past;

	assign hit = (IDX == at);
	assign past = (IDX > at);

	always_comb begin
		data_d = data_q;
		case (ctl.kind)
			pls_pkg::CELL_INSERT: begin
				if (hit) begin
					data_d = ctl.value;
				end else if (past) begin
					data_d = left_data;
				end
			end
			pls_pkg::CELL_REMOVE: begin
				if (hit || past) begin
					data_d = right_data;
				end
			end
			default: begin
				data_d = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;
	assign rd_term = hit ? data_q : '0;

endmodule

@@ hdl/positional_list_store_unit.sv @@
// Ordered store of up to CAPACITY signed 32-bit items, position 0 at the front. Each command
// beat (operation, value, position) gives exactly one result beat, held in an output register
// loaded on acceptance; a new command is taken every cycle while that register is empty or its
// result is being taken, so the sustained rate is one command per cycle. The items live in a
// row of cells that shift toward the back on an insert and toward the front on a remove, all
// in the same cycle; reads and removes pick the addressed cell through a one-hot select across
// the row. Item storage is not reset; arst_n clears only the item count and the result valid
// flag. Positions are five bits wide, so with a capacity above 32 the deeper items are
// reachable only from the front and the back, and count reports the low five bits of the item
// count.
module positional_list_store_unit #(
	parameter int CAPACITY = pls_pkg::CAPACITY_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [pls_pkg::OP_W-1:0]          operation,
	input  logic signed [pls_pkg::VAL_W-1:0]  value,
	input  logic [pls_pkg::POS_W-1:0]         position,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [pls_pkg::VAL_W-1:0]  result_value,
	output logic [pls_pkg::ST_W-1:0]          status,
	output logic [pls_pkg::CNT_W-1:0]         count,
	output logic                              is_empty
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > pls_pkg::POS_W) ? CW : pls_pkg::POS_W;
	localparam logic [XW-1:0] CAP_X = XW'(CAPACITY);

	logic [CW-1:0]                    count_q;
	logic [CW-1:0]                    count_d;
	logic                             accept;
	pls_pkg::op_t                     op_e;
	pls_pkg::status_t                 st;
	pls_pkg::cell_cmd_t               kind;
	pls_pkg::cell_ctl_t               ctl;
	logic [CW-1:0]                    at_w;
	logic [XW-1:0]                    cnt_x;
	logic [XW-1:0]                    pos_x;
	logic [XW-1:0]                    ins_x;
	logic signed [pls_pkg::VAL_W-1:0] rv;
	logic signed [pls_pkg::VAL_W-1:0] rd_bus;
	logic signed [pls_pkg::VAL_W-1:0] cell_data [CAPACITY];
	logic signed [pls_pkg::VAL_W-1:0] cell_rd [CAPACITY];

	logic                             out_valid_q;
	logic signed [pls_pkg::VAL_W-1:0] res_value_q;
	pls_pkg::status_t                 res_status_q;
	logic [CW-1:0]                    res_count_q;
	logic                             res_empty_q;
	logic [XW-1:0]                    res_count_x;

	assign accept = in_valid && in_ready;
	assign in_ready = !out_valid_q || out_ready;
	assign op_e = pls_pkg::op_t'(operation);
	assign cnt_x = XW'(count_q);
	assign pos_x = XW'(position);

	always_comb begin
		case (op_e)
			pls_pkg::OP_PUSH_FRONT: ins_x = '0;
			pls_pkg::OP_PUSH_BACK:  ins_x = cnt_x;
			default:                ins_x = pos_x;
		endcase
	end

	always_comb begin
		case (op_e)
			pls_pkg::OP_PUSH_BACK: begin
				at_w = count_q;
			end
			pls_pkg::OP_INSERT_AT, pls_pkg::OP_REMOVE_AT, pls_pkg::OP_READ_AT: begin
				at_w = CW'(position);
			end
			pls_pkg::OP_POP_BACK, pls_pkg::OP_READ_BACK: begin
				at_w = CW'(count_q - 1'b1);
			end
			default: begin
				at_w = '0;
			end
		endcase
	end

	always_comb begin
		rd_bus = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_bus = rd_bus | cell_rd[i];
		end
	end

	always_comb begin
		st = pls_pkg::ST_OK;
		kind = pls_pkg::CELL_HOLD;
		count_d = count_q;
		rv = '0;
		case (op_e)
			pls_pkg::OP_PUSH_FRONT, pls_pkg::OP_PUSH_BACK, pls_pkg::OP_INSERT_AT: begin
				if (ins_x > cnt_x) begin
					st = pls_pkg::ST_BADPOS;
				end else if (cnt_x >= CAP_X) begin
					st = pls_pkg::ST_FULL;
				end else begin
					kind = pls_pkg::CELL_INSERT;
					count_d = CW'(count_q + 1'b1);
					rv = value;
				end
			end
			pls_pkg::OP_POP_FRONT, pls_pkg::OP_POP_BACK: begin
				if (count_q == '0) begin
					st = pls_pkg::ST_EMPTY;
				end else begin
					kind = pls_pkg::CELL_REMOVE;
					count_d = CW'(count_q - 1'b1);
					rv = rd_bus;
				end
			end
			pls_pkg::OP_READ_FRONT, pls_pkg::OP_READ_BACK: begin
				if (count_q == '0) begin
					st = pls_pkg::ST_EMPTY;
				end else begin
					rv = rd_bus;
				end
			end
			pls_pkg::OP_REMOVE_AT: begin
				if (count_q == '0) begin
					st = pls_pkg::ST_EMPTY;
				end else if (pos_x >= cnt_x) begin
					st = pls_pkg::ST_BADPOS;
				end else begin
					kind = pls_pkg::CELL_REMOVE;
					count_d = CW'(count_q - 1'b1);
					rv = rd_bus;
				end
			end
			pls_pkg::OP_READ_AT: begin
				if (pos_x >= cnt_x) begin
					st = pls_pkg::ST_BADPOS;
				end else begin
					rv = rd_bus;
				end
			end
			pls_pkg::OP_CLEAR: begin
				count_d = '0;
			end
			default: begin
				rv = '0;
			end
		endcase
		if (st != pls_pkg::ST_OK) begin
			rv = pls_pkg::ERR_VALUE;
		end
	end

	assign ctl.kind = accept ? kind : pls_pkg::CELL_HOLD;
	assign ctl.value = value;

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic signed [pls_pkg::VAL_W-1:0] left_w;
		logic signed [pls_pkg::VAL_W-1:0] right_w;

		if (g == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cell_data[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = cell_data[g+1];
		end

		pls_cell #(
			.CountWidth(CW),
			.Index(g)
		) u_cell (
			.clk(clk),
			.ctl(ctl),
			.at(at_w),
			.left_data(left_w),
			.right_data(right_w),
			.data(cell_data[g]),
			.rd_term(cell_rd[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_value_q <= rv;
			res_status_q <= st;
			res_count_q <= count_d;
			res_empty_q <= (count_d == '0);
		end
	end

	assign res_count_x = XW'(res_count_q);
	assign out_valid = out_valid_q;
	assign result_value = res_value_q;
	assign status = res_status_q;
	assign count = res_count_x[pls_pkg::CNT_W-1:0];
	assign is_empty = res_empty_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		XW'(count_q) <= CAP_X)
		else $error("item count exceeds capacity");

	a_count_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(count_q))
		else $error("item count changed without a command");

	a_err_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (res_status_q != pls_pkg::ST_OK) |-> res_value_q == pls_pkg::ERR_VALUE)
		else $error("error result without the error value");

	a_result_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (res_count_q == count_q) && (res_empty_q == (count_q == '0)))
		else $error("reported count differs from the stored count");

endmodule

@@ test/testbench.sv @@
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import pls_pkg::*;

	localparam int CAP = CAPACITY_DEF;
	localparam int RANDOM_ITEMS = 500;

	typedef struct {
		logic [OP_W-1:0]          op;
		logic signed [VAL_W-1:0]  val;
		logic [POS_W-1:0]         pos;
		int                       gap;
		bit                       drain;
	} command_t;

	typedef struct {
		logic signed [VAL_W-1:0]  value;
		status_t                  status;
		logic [CNT_W-1:0]         count;
		logic                     empty;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [OP_W-1:0] operation = '0;
	logic signed [VAL_W-1:0] value = '0;
	logic [POS_W-1:0] position = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [VAL_W-1:0] result_value;
	logic [ST_W-1:0] status;
	logic [CNT_W-1:0] count;
	logic is_empty;

	command_t pending[$];
	outcome_t expected[$];
	logic signed [VAL_W-1:0] store_cells[CAP];
	int held_count = 0;
	int fail_count = 0;
	int wait_left = 0;
	bit gap_loaded = 1'b0;
	bit calm_sender = 1'b0;
	int stall_left = 0;
	int stall_pct = 10;

	positional_list_store_unit #(.CAPACITY(CAP)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.value(value),
		.position(position),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_value(result_value),
		.status(status),
		.count(count),
		.is_empty(is_empty)
	);

	initial forever #1 clk = ~clk;

	function automatic outcome_t apply_command(input logic [OP_W-1:0] op,
			input logic signed [VAL_W-1:0] val, input logic [POS_W-1:0] pos);
		outcome_t r;
		int at;
		int i;
		r.value = '0;
		r.status = ST_OK;
		at = 0;
		case (op)
			OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT_AT: begin
				if (op == OP_PUSH_BACK)
					at = held_count;
				else if (op == OP_INSERT_AT)
					at = int'(pos);
				if (at > held_count) begin
					r.status = ST_BADPOS;
				end else if (held_count >= CAP) begin
					r.status = ST_FULL;
				end else begin
					for (i = held_count; i > at; i--)
						store_cells[i] = store_cells[i-1];
					store_cells[at] = val;
					held_count++;
					r.value = val;
				end
			end
			OP_POP_FRONT, OP_POP_BACK, OP_READ_FRONT, OP_READ_BACK: begin
				if (held_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					at = (op == OP_POP_FRONT || op == OP_READ_FRONT) ? 0 : held_count - 1;
					r.value = store_cells[at];
					if (op == OP_POP_FRONT || op == OP_POP_BACK) begin
						for (i = at; i + 1 < held_count; i++)
							store_cells[i] = store_cells[i+1];
						held_count--;
					end
				end
			end
			OP_REMOVE_AT: begin
				if (held_count == 0) begin
					r.status = ST_EMPTY;
				end else if (int'(pos) >= held_count) begin
					r.status = ST_BADPOS;
				end else begin
					r.value = store_cells[pos];
					for (i = int'(pos); i + 1 < held_count; i++)
						store_cells[i] = store_cells[i+1];
					held_count--;
				end
			end
			OP_READ_AT: begin
				if (int'(pos) >= held_count)
					r.status = ST_BADPOS;
				else
					r.value = store_cells[pos];
			end
			OP_CLEAR: begin
				held_count = 0;
			end
			default: begin
			end
		endcase
		if (r.status != ST_OK)
			r.value = ERR_VALUE;
		r.count = CNT_W'(held_count);
		r.empty = (held_count == 0);
		return r;
	endfunction

	task automatic add_command(input logic [OP_W-1:0] op, input logic signed [VAL_W-1:0] val,
			input logic [POS_W-1:0] pos, input bit drain);
		command_t c;
		int roll;
		roll = $urandom_range(0, 99);
		c.op = op;
		c.val = val;
		c.pos = pos;
		c.drain = drain;
		if (calm_sender || roll < 60)
			c.gap = 0;
		else if (roll < 90)
			c.gap = $urandom_range(1, 3);
		else
			c.gap = $urandom_range(6, 25);
		pending.push_back(c);
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic go;
		command_t c;
		outcome_t o;
		go = 1'b0;
		if (!arst_n) begin
			in_valid <= 1'b0;
			operation <= '0;
			value <= '0;
			position <= '0;
			gap_loaded = 1'b0;
			wait_left = 0;
		end else begin
			if (in_valid && in_ready) begin
				o = apply_command(operation, value, position);
				expected.push_back(o);
			end
			if (!in_valid || in_ready) begin
				if (pending.size() > 0) begin
					if (!gap_loaded) begin
						wait_left = pending[0].gap;
						gap_loaded = 1'b1;
					end
					if (wait_left > 0)
						wait_left--;
					else if (!pending[0].drain || expected.size() == 0)
						go = 1'b1;
				end
				if (go) begin
					c = pending.pop_front();
					gap_loaded = 1'b0;
					in_valid <= 1'b1;
					operation <= c.op;
					value <= c.val;
					position <= c.pos;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		outcome_t e;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected.size() == 0) begin
					$error("result beat with no command waiting");
					fail_count++;
				end else begin
					e = expected.pop_front();
					if (result_value !== e.value) begin
						$error("result_value: expected %0d, got %0d", e.value, result_value);
						fail_count++;
					end
					if (status !== e.status) begin
						$error("status: expected %0d, got %0d", e.status, status);
						fail_count++;
					end
					if (count !== e.count) begin
						$error("count: expected %0d, got %0d", e.count, count);
						fail_count++;
					end
					if (is_empty !== e.empty) begin
						$error("is_empty: expected %0d, got %0d", e.empty, is_empty);
						fail_count++;
					end
				end
			end
			if ($urandom_range(0, 199) == 0)
				stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 35);
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if ($urandom_range(0, 99) < stall_pct) begin
				stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) :
					$urandom_range(0, 2);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		int roll;
		int insert_pct;
		int remove_pct;
		logic [OP_W-1:0] op;
		logic [POS_W-1:0] pos;

		add_command(OP_READ_FRONT, 32'sd5, 5'd0, 1'b0);
		add_command(OP_POP_BACK, 32'sd0, 5'd0, 1'b0);
		add_command(OP_REMOVE_AT, 32'sd0, 5'd0, 1'b0);
		add_command(OP_READ_AT, 32'sd0, 5'd0, 1'b0);
		add_command(OP_INSERT_AT, 32'sd9, 5'd1, 1'b0);
		add_command(OP_PUSH_FRONT, 32'sh7fffffff, 5'd31, 1'b0);
		add_command(OP_PUSH_BACK, 32'sh80000000, 5'd0, 1'b0);
		add_command(OP_INSERT_AT, -32'sd1, 5'd1, 1'b0);
		add_command(OP_INSERT_AT, 32'sd0, 5'd3, 1'b0);
		add_command(OP_READ_AT, 32'sd0, 5'd2, 1'b0);
		add_command(OP_READ_BACK, 32'sd0, 5'd0, 1'b0);
		add_command(OP_READ_FRONT, 32'sd0, 5'd0, 1'b0);
		add_command(OP_READ_AT, 32'sd0, 5'd4, 1'b0);
		add_command(OP_REMOVE_AT, 32'sd0, 5'd31, 1'b0);
		add_command(OP_REMOVE_AT, 32'sd0, 5'd1, 1'b0);
		add_command(OP_POP_FRONT, 32'sd0, 5'd0, 1'b0);
		add_command(OP_POP_BACK, 32'sd0, 5'd0, 1'b0);
		add_command(4'd10, 32'sd77, 5'd3, 1'b0);
		add_command(4'd15, -32'sd77, 5'd16, 1'b0);
		add_command(OP_CLEAR, 32'sd0, 5'd0, 1'b0);
		add_command(OP_CLEAR, 32'sd0, 5'd0, 1'b0);
		add_command(OP_INSERT_AT, 32'sh55555555, 5'd0, 1'b1);
		add_command(OP_PUSH_FRONT, 32'shaaaaaaaa, 5'd0, 1'b0);

		insert_pct = 40;
		remove_pct = 30;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0) begin
				calm_sender = ($urandom_range(0, 3) == 0);
				case ($urandom_range(0, 2))
					0: begin
						insert_pct = 70;
						remove_pct = 12;
					end
					1: begin
						insert_pct = 18;
						remove_pct = 55;
					end
					default: begin
						insert_pct = 40;
						remove_pct = 30;
					end
				endcase
			end
			roll = $urandom_range(0, 99);
			if (roll < 3)
				op = OP_W'($urandom_range(10, 15));
			else if (roll == 3)
				op = OP_CLEAR;
			else if (roll < 4 + insert_pct)
				op = OP_W'($urandom_range(0, 2));
			else if (roll < 4 + insert_pct + remove_pct)
				op = OP_W'($urandom_range(3, 5));
			else
				op = OP_W'($urandom_range(6, 8));
			if ($urandom_range(0, 99) < 85)
				pos = POS_W'($urandom_range(0, CAP));
			else
				pos = POS_W'($urandom_range(0, 31));
			add_command(op, VAL_W'($urandom), pos, (n % 150 == 149));
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		while (pending.size() != 0 || in_valid || expected.size() != 0)
			@(negedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && expected.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
